// ----- rtl/pswc_pkg.sv -----
// ============================================================================
// pswc_pkg: shared types and codes for the pressure-switch output channel
// Holds the item structs, request and mode codes and configuration indexes.
// ============================================================================
package pswc_pkg;

    // Request codes carried by an input item
    localparam logic [1:0] REQ_SCAN  = 2'd0;
    localparam logic [1:0] REQ_ARM   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Evaluation modes
    localparam logic [1:0] MODE_SIMPLE = 2'd0;
    localparam logic [1:0] MODE_LAG    = 2'd1;
    localparam logic [1:0] MODE_WINDOW = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_LEVEL    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_VALLEY_LEVEL  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HYSTERESIS    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESPONSE_TIME = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_LEVEL  = 3'd6;

    localparam int unsigned CFG_DATA_W = 32;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] pressure;
        logic [31:0]        now_tick;
    } in_item_t;

    typedef struct packed {
        logic output_on;
        logic drive_level;
    } out_item_t;

endpackage

// ----- rtl/pressure_switch_output_channel.sv -----
// ============================================================================
// pressure_switch_output_channel: one pressure-switch output channel
// Comparator with hysteresis, lag and window modes and a tick-based on-delay.
// ============================================================================
//
//  channel | handshake             | payload     | direction
//  --------+-----------------------+-------------+----------
//  in      | in_valid / in_stall   | in_item_t   | into block
//  out     | out_valid / out_stall | out_item_t  | out of block
//  cfg     | cfg_wr_en             | cfg_index,  | into block
//          |                       | cfg_wr_data |
//
//  One item is taken per cycle while in_stall is low; its state update and
//  result are formed in the cycle it is accepted, and the result is held in
//  the output register, or in a one-entry skid stage while the output stalls:
//  in_stall rises only when both hold an undelivered item.
//  Reset clears all channel state and loads the register defaults
//  (active_level 1, all others 0). No clearing pass is needed.
//
module pressure_switch_output_channel
    import pswc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_item
);

    // Configuration registers
    logic [1:0]         mode_reg;
    logic signed [31:0] threshold_reg;
    logic signed [31:0] peak_level_reg;
    logic signed [31:0] valley_level_reg;
    logic signed [31:0] hysteresis_reg;
    logic [30:0]        response_time_reg;
    logic               active_level_reg;

    // Channel state
    logic        armed_reg,         armed_next;
    logic        cond_met_reg,      cond_met_next;
    logic        timing_reg,        timing_next;
    logic        is_on_reg,         is_on_next;
    logic        window_inside_reg, window_inside_next;
    logic        off_pending_reg,   off_pending_next;
    logic        off_sent_reg,      off_sent_next;
    logic [31:0] start_tick_reg,    start_tick_next;

    // Output register and skid stage
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      skid_valid_reg;
    out_item_t skid_item_reg;

    logic      in_acc;
    logic      res_valid;
    out_item_t res_item;

    // Comparison operands, widened to 33 bits so sums cannot wrap
    logic signed [32:0] p33;
    logic signed [32:0] thr33;
    logic signed [32:0] peak33;
    logic signed [32:0] valley33;
    logic signed [32:0] thr_hys33;
    logic signed [32:0] peak_hys33;
    logic signed [32:0] valley_hys33;
    logic [31:0]        elapsed;

    // Flags after mode evaluation
    logic ev_cond, ev_timing, ev_on, ev_win, ev_offp;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign p33          = {in_item.pressure[31], in_item.pressure};
    assign thr33        = {threshold_reg[31], threshold_reg};
    assign peak33       = {peak_level_reg[31], peak_level_reg};
    assign valley33     = {valley_level_reg[31], valley_level_reg};
    assign thr_hys33    = thr33 + {hysteresis_reg[31], hysteresis_reg};
    assign peak_hys33   = peak33 + {hysteresis_reg[31], hysteresis_reg};
    assign valley_hys33 = valley33 + {hysteresis_reg[31], hysteresis_reg};

    // Evaluate the selected mode on an armed sample
    always_comb
    begin
        ev_cond   = cond_met_reg;
        ev_timing = timing_reg;
        ev_on     = is_on_reg;
        ev_win    = window_inside_reg;
        ev_offp   = off_pending_reg;
        if (armed_reg)
        begin
            unique case (mode_reg)
                MODE_SIMPLE:
                begin
                    if (p33 > thr_hys33)
                    begin
                        ev_cond = 1'b1;
                    end
                    else if (p33 < thr33)
                    begin
                        ev_cond   = 1'b0;
                        ev_timing = 1'b0;
                        ev_on     = 1'b0;
                        ev_offp   = 1'b1;
                    end
                end
                MODE_LAG:
                begin
                    if (p33 > peak33)
                    begin
                        ev_cond = 1'b1;
                    end
                    else if (p33 < valley33)
                    begin
                        ev_cond   = 1'b0;
                        ev_timing = 1'b0;
                        ev_on     = 1'b0;
                        ev_offp   = 1'b1;
                    end
                end
                MODE_WINDOW:
                begin
                    // outside tests, which may move the inside flag
                    if (!ev_win)
                    begin
                        if (p33 > peak_hys33)
                        begin
                            ev_cond   = 1'b0;
                            ev_timing = 1'b0;
                            ev_on     = 1'b0;
                            ev_offp   = 1'b1;
                            ev_win    = 1'b1;
                        end
                        else if (p33 > valley_hys33)
                        begin
                            ev_cond = 1'b1;
                        end
                        else if (p33 < valley33)
                        begin
                            ev_cond   = 1'b0;
                            ev_timing = 1'b0;
                            ev_on     = 1'b0;
                            ev_offp   = 1'b1;
                            ev_win    = 1'b0;
                        end
                    end
                    // inside tests on the updated flag
                    if (ev_win)
                    begin
                        if (p33 < peak33 && p33 > valley33)
                        begin
                            ev_cond = 1'b1;
                        end
                        else if (p33 > peak_hys33)
                        begin
                            ev_cond   = 1'b0;
                            ev_timing = 1'b0;
                            ev_on     = 1'b0;
                            ev_offp   = 1'b1;
                        end
                        else if (p33 < valley33)
                        begin
                            ev_cond   = 1'b0;
                            ev_timing = 1'b0;
                            ev_on     = 1'b0;
                            ev_offp   = 1'b1;
                            ev_win    = 1'b0;
                        end
                    end
                end
                default:
                begin
                    // unused mode: nothing evaluated
                end
            endcase
        end
    end

    // Run the on-delay and form the result of one item
    always_comb
    begin
        armed_next         = armed_reg;
        cond_met_next      = cond_met_reg;
        timing_next        = timing_reg;
        is_on_next         = is_on_reg;
        window_inside_next = window_inside_reg;
        off_pending_next   = off_pending_reg;
        off_sent_next      = off_sent_reg;
        start_tick_next    = start_tick_reg;
        res_valid          = 1'b0;
        res_item           = '0;
        elapsed            = '0;

        unique case (in_item.req_type)
            REQ_ARM:
            begin
                armed_next = 1'b1;
            end
            REQ_CLEAR:
            begin
                armed_next         = 1'b0;
                cond_met_next      = 1'b0;
                timing_next        = 1'b0;
                is_on_next         = 1'b0;
                window_inside_next = 1'b0;
                off_pending_next   = 1'b0;
                off_sent_next      = 1'b0;
                start_tick_next    = '0;
            end
            REQ_SCAN:
            begin
                armed_next         = 1'b0;
                cond_met_next      = ev_cond;
                timing_next        = ev_timing;
                is_on_next         = ev_on;
                window_inside_next = ev_win;
                off_pending_next   = ev_offp;
                if (!ev_on)
                begin
                    // start timing on a fresh condition
                    if (!ev_timing && ev_cond)
                    begin
                        timing_next     = 1'b1;
                        cond_met_next   = 1'b0;
                        start_tick_next = in_item.now_tick;
                    end
                    elapsed = in_item.now_tick - start_tick_next;
                    if (timing_next && elapsed > {1'b0, response_time_reg})
                    begin
                        is_on_next           = 1'b1;
                        off_pending_next     = 1'b0;
                        off_sent_next        = 1'b0;
                        res_valid            = 1'b1;
                        res_item.output_on   = 1'b1;
                        res_item.drive_level = active_level_reg;
                    end
                end
                // emit a single off item
                if (off_pending_next && !off_sent_next)
                begin
                    off_sent_next        = 1'b1;
                    res_valid            = 1'b1;
                    res_item.output_on   = 1'b0;
                    res_item.drive_level = !active_level_reg;
                end
            end
            default:
            begin
                // unused request: ignore
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_SIMPLE;
            threshold_reg     <= '0;
            peak_level_reg    <= '0;
            valley_level_reg  <= '0;
            hysteresis_reg    <= '0;
            response_time_reg <= '0;
            active_level_reg  <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MODE:          mode_reg          <= cfg_wr_data[1:0];
                CFG_THRESHOLD:     threshold_reg     <= cfg_wr_data;
                CFG_PEAK_LEVEL:    peak_level_reg    <= cfg_wr_data;
                CFG_VALLEY_LEVEL:  valley_level_reg  <= cfg_wr_data;
                CFG_HYSTERESIS:    hysteresis_reg    <= cfg_wr_data;
                CFG_RESPONSE_TIME: response_time_reg <= cfg_wr_data[30:0];
                CFG_ACTIVE_LEVEL:  active_level_reg  <= cfg_wr_data[0];
                default:
                begin
                    // no register at this index: drop the write
                end
            endcase
        end
    end

    // Advance channel state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg         <= 1'b0;
            cond_met_reg      <= 1'b0;
            timing_reg        <= 1'b0;
            is_on_reg         <= 1'b0;
            window_inside_reg <= 1'b0;
            off_pending_reg   <= 1'b0;
            off_sent_reg      <= 1'b0;
            start_tick_reg    <= '0;
        end
        else if (in_acc)
        begin
            armed_reg         <= armed_next;
            cond_met_reg      <= cond_met_next;
            timing_reg        <= timing_next;
            is_on_reg         <= is_on_next;
            window_inside_reg <= window_inside_next;
            off_pending_reg   <= off_pending_next;
            off_sent_reg      <= off_sent_next;
            start_tick_reg    <= start_tick_next;
        end
    end

    // Hold results in the output register, spilling into the skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_acc && res_valid;
            end
        end
        else if (in_acc && res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload of the output register and skid stage
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_item_reg <= skid_item_reg;
            end
            else
            begin
                out_item_reg <= res_item;
            end
        end
        else if (in_acc && res_valid)
        begin
            skid_item_reg <= res_item;
        end
    end

endmodule

// ----- tb/sv/tb_pressure_switch_output_channel.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_pressure_switch_output_channel: self-checking bench for one channel
// Drives arm, scan and clear items through the valid/stall input, mirrors
// the channel state and on-delay in a local model and compares every result
// item, in order, with the model's prediction. Directed cases cover the
// level extremes, every mode and the wrapping tick; random traffic runs
// under three idling profiles, and a directed test holds the output off long.
// ============================================================================
module tb_pressure_switch_output_channel;
    import pswc_pkg::*;

    localparam logic [1:0]         REQ_UNUSED   = 2'd3;
    localparam logic [1:0]         MODE_UNUSED  = 2'd3;
    localparam logic signed [31:0] P_MAX        = 32'sh7FFFFFFF;
    localparam logic signed [31:0] P_MIN        = 32'sh80000000;
    localparam logic [30:0]        RESP_MAX     = 31'h7FFFFFFF;
    localparam int                 DRAIN_CYCLES = 8;
    localparam int                 LIMIT_CYCLES = 400000;

    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] threshold;
        logic signed [31:0] peak;
        logic signed [31:0] valley;
        logic signed [31:0] hyst;
        logic [30:0]        resp_time;
        logic               active;
    } chan_cfg_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_item;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_item;

    // Mirror of the channel: configuration and state
    chan_cfg_t   chan_cfg;
    logic        st_armed;
    logic        st_cond;
    logic        st_timing;
    logic        st_on;
    logic        st_inside;
    logic        st_off_pend;
    logic        st_off_sent;
    logic [31:0] st_start;

    out_item_t   switch_events_q[$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_request;
    int          hold_left;
    logic [31:0] tick_now;

    pressure_switch_output_channel dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

    always #6 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Output side: random stall, or hold off for a requested stretch
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each delivered item with the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (switch_events_q.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, got on=%0b level=%0b",
                         $time, out_item.output_on, out_item.drive_level);
                error_count++;
            end
            else
            begin
                want = switch_events_q.pop_front();
                if (out_item.output_on !== want.output_on)
                begin
                    $display("%0t: output_on wrong: expected %0b, got %0b",
                             $time, want.output_on, out_item.output_on);
                    error_count++;
                end
                if (out_item.drive_level !== want.drive_level)
                begin
                    $display("%0t: drive_level wrong: expected %0b, got %0b",
                             $time, want.drive_level, out_item.drive_level);
                    error_count++;
                end
            end
        end
    end

    // Level plus hysteresis at 33 bits, so the sum never wraps
    function automatic logic signed [32:0] wide_sum(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        return {a[31], a} + {b[31], b};
    endfunction

    function automatic void force_off(input logic leave_window);
        st_cond = 1'b0;
        st_timing = 1'b0;
        st_on = 1'b0;
        if (leave_window)
            st_inside = 1'b0;
        st_off_pend = 1'b1;
    endfunction

    function automatic void clear_channel();
        st_armed = 1'b0;
        st_cond = 1'b0;
        st_timing = 1'b0;
        st_on = 1'b0;
        st_inside = 1'b0;
        st_off_pend = 1'b0;
        st_off_sent = 1'b0;
        st_start = '0;
    endfunction

    // Advance the mirror by one accepted item and queue any switch event
    function automatic void step_channel(input in_item_t it);
        logic signed [31:0] p;
        logic [31:0]        elapsed;
        out_item_t          ev;
        logic               got;
        p = it.pressure;
        got = 1'b0;
        ev = '0;
        case (it.req_type)
            REQ_ARM: st_armed = 1'b1;
            REQ_CLEAR: clear_channel();
            REQ_SCAN:
            begin
                if (st_armed)
                begin
                    case (chan_cfg.mode)
                        MODE_SIMPLE:
                        begin
                            if (p > wide_sum(chan_cfg.threshold, chan_cfg.hyst))
                                st_cond = 1'b1;
                            else if (p < chan_cfg.threshold)
                                force_off(1'b0);
                        end
                        MODE_LAG:
                        begin
                            if (p > chan_cfg.peak)
                                st_cond = 1'b1;
                            else if (p < chan_cfg.valley)
                                force_off(1'b0);
                        end
                        MODE_WINDOW:
                        begin
                            // outside tests first, then inside tests on the new flag
                            if (!st_inside)
                            begin
                                if (p > wide_sum(chan_cfg.peak, chan_cfg.hyst))
                                begin
                                    force_off(1'b0);
                                    st_inside = 1'b1;
                                end
                                else if (p > wide_sum(chan_cfg.valley, chan_cfg.hyst))
                                    st_cond = 1'b1;
                                else if (p < chan_cfg.valley)
                                    force_off(1'b1);
                            end
                            if (st_inside)
                            begin
                                if (p < chan_cfg.peak && p > chan_cfg.valley)
                                    st_cond = 1'b1;
                                else if (p > wide_sum(chan_cfg.peak, chan_cfg.hyst))
                                    force_off(1'b0);
                                else if (p < chan_cfg.valley)
                                    force_off(1'b1);
                            end
                        end
                        default: ;
                    endcase
                    st_armed = 1'b0;
                end
                // on-delay, measured on the wrapping tick
                if (!st_on)
                begin
                    if (!st_timing && st_cond)
                    begin
                        st_timing = 1'b1;
                        st_cond = 1'b0;
                        st_start = it.now_tick;
                    end
                    elapsed = it.now_tick - st_start;
                    if (st_timing && elapsed > {1'b0, chan_cfg.resp_time})
                    begin
                        st_on = 1'b1;
                        st_off_pend = 1'b0;
                        st_off_sent = 1'b0;
                        ev.output_on = 1'b1;
                        ev.drive_level = chan_cfg.active;
                        got = 1'b1;
                    end
                end
                // report a switch-off only once
                if (st_off_pend && !st_off_sent)
                begin
                    st_off_sent = 1'b1;
                    ev.output_on = 1'b0;
                    ev.drive_level = ~chan_cfg.active;
                    got = 1'b1;
                end
                if (got)
                    switch_events_q.push_back(ev);
            end
            default: ;
        endcase
    endfunction

    function automatic chan_cfg_t make_cfg(input logic [1:0] mode,
                                           input logic signed [31:0] threshold,
                                           input logic signed [31:0] peak,
                                           input logic signed [31:0] valley,
                                           input logic signed [31:0] hyst,
                                           input logic [30:0] resp_time,
                                           input logic active);
        chan_cfg_t c;
        c.mode = mode;
        c.threshold = threshold;
        c.peak = peak;
        c.valley = valley;
        c.hyst = hyst;
        c.resp_time = resp_time;
        c.active = active;
        return c;
    endfunction

    function automatic logic signed [31:0] extreme_word();
        case ($urandom_range(2))
            0: return P_MIN;
            1: return P_MAX;
            default: return $urandom;
        endcase
    endfunction

    function automatic chan_cfg_t random_config(input logic wide);
        chan_cfg_t c;
        c.mode = ($urandom_range(9) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
        c.active = 1'($urandom_range(1));
        if (wide)
        begin
            c.threshold = extreme_word();
            c.peak = extreme_word();
            c.valley = extreme_word();
            c.hyst = extreme_word();
            c.resp_time = $urandom_range(1) ? RESP_MAX : 31'($urandom);
        end
        else
        begin
            c.valley = int'($urandom_range(100)) - 50;
            c.peak = c.valley + int'($urandom_range(30));
            c.threshold = int'($urandom_range(100)) - 50;
            c.hyst = int'($urandom_range(12)) - 4;
            c.resp_time = 31'($urandom_range(6));
        end
        return c;
    endfunction

    // Pressure near one of the configured levels, or anywhere
    function automatic logic signed [31:0] pick_pressure();
        int delta;
        delta = int'($urandom_range(24)) - 12;
        case ($urandom_range(3))
            0: return $urandom;
            1: return chan_cfg.threshold + delta;
            2: return chan_cfg.peak + delta;
            default: return chan_cfg.valley + delta;
        endcase
    endfunction

    // Drop valid and let the channel drain before touching registers
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (switch_events_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(input chan_cfg_t c);
        logic [31:0] regs [7];
        regs[CFG_MODE] = {30'b0, c.mode};
        regs[CFG_THRESHOLD] = c.threshold;
        regs[CFG_PEAK_LEVEL] = c.peak;
        regs[CFG_VALLEY_LEVEL] = c.valley;
        regs[CFG_HYSTERESIS] = c.hyst;
        regs[CFG_RESPONSE_TIME] = {1'b0, c.resp_time};
        regs[CFG_ACTIVE_LEVEL] = {31'b0, c.active};
        wait_idle();
        for (int i = 0; i <= int'(CFG_ACTIVE_LEVEL); i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= i[CFG_INDEX_W-1:0];
            cfg_wr_data <= regs[i];
            @(posedge clk);
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        chan_cfg = c;
    endtask

    // Offer one item, hold it while stalled, update the mirror on acceptance
    task automatic send_item(input logic [1:0] req, input logic signed [31:0] p,
                             input logic [31:0] t);
        in_item_t it;
        it.req_type = req;
        it.pressure = p;
        it.now_tick = t;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        step_channel(it);
    endtask

    // Reset defaults: ignored items, on after the delay, then an off and one silent re-off
    task automatic test_defaults();
        send_item(REQ_SCAN, P_MAX, 32'd50);
        send_item(REQ_UNUSED, P_MIN, 32'hFFFF_FFFF);
        send_item(REQ_ARM, 32'sd0, 32'd99);
        send_item(REQ_SCAN, 32'sd1, 32'd100);
        send_item(REQ_SCAN, 32'sd0, 32'd101);
        send_item(REQ_ARM, 32'sd0, 32'd102);
        send_item(REQ_SCAN, -32'sd1, 32'd102);
        send_item(REQ_ARM, 32'sd0, 32'd103);
        send_item(REQ_SCAN, P_MIN, 32'd103);
    endtask

    // Level sums at the edges of the range, maximum delay across the tick wrap
    task automatic test_level_extremes();
        set_config(make_cfg(MODE_SIMPLE, P_MAX, 32'sd0, 32'sd0, P_MAX, '0, 1'b1));
        send_item(REQ_ARM, P_MAX, 32'd0);
        send_item(REQ_SCAN, P_MAX, 32'd0);
        set_config(make_cfg(MODE_SIMPLE, P_MIN, 32'sd0, 32'sd0, P_MIN, RESP_MAX, 1'b1));
        send_item(REQ_ARM, P_MIN, 32'hFFFF_FFF0);
        send_item(REQ_SCAN, P_MIN, 32'hFFFF_FFF0);
        send_item(REQ_SCAN, P_MIN, 32'h7FFF_FFF0);
    endtask

    // Lag, window in and out, and the unused mode
    task automatic test_modes();
        set_config(make_cfg(MODE_LAG, 32'sd0, 32'sd10, -32'sd10, 32'sd0, '0, 1'b0));
        send_item(REQ_ARM, 32'sd0, 32'd1);
        send_item(REQ_SCAN, -32'sd11, 32'd1);
        set_config(make_cfg(MODE_WINDOW, 32'sd0, 32'sd10, -32'sd10, 32'sd2, '0, 1'b1));
        send_item(REQ_CLEAR, 32'sd0, 32'd2);
        send_item(REQ_ARM, 32'sd0, 32'd2);
        send_item(REQ_SCAN, 32'sd13, 32'd3);
        send_item(REQ_ARM, 32'sd0, 32'd4);
        send_item(REQ_SCAN, 32'sd0, 32'd4);
        send_item(REQ_ARM, 32'sd0, 32'd5);
        send_item(REQ_SCAN, -32'sd11, 32'd5);
        set_config(make_cfg(MODE_UNUSED, 32'sd0, 32'sd0, 32'sd0, 32'sd0, '0, 1'b1));
        send_item(REQ_ARM, 32'sd0, 32'd6);
        send_item(REQ_SCAN, P_MAX, 32'd6);
    endtask

    // Hold the output off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        set_config(make_cfg(MODE_SIMPLE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, '0, 1'b1));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_item(REQ_CLEAR, 32'sd0, tick_now);
        hold_request = 60;
        for (int i = 0; i < 8; i++)
        begin
            tick_now = tick_now + 32'd2;
            send_item(REQ_ARM, 32'sd0, tick_now);
            send_item(REQ_SCAN, 32'sd100, tick_now);
            send_item(REQ_SCAN, 32'sd100, tick_now + 32'd1);
            send_item(REQ_ARM, 32'sd0, tick_now);
            send_item(REQ_SCAN, -32'sd100, tick_now + 32'd1);
        end
    endtask

    // Mostly arm-then-scan runs with random content, plus noise
    task automatic run_random_phase(input int n_items, input int s_pct, input int r_pct);
        int sent;
        int next_cfg;
        int cfg_num;
        int kind;
        sent = 0;
        next_cfg = 0;
        cfg_num = 0;
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        while (sent < n_items)
        begin
            if (sent >= next_cfg)
            begin
                set_config(random_config(cfg_num % 4 == 3));
                cfg_num++;
                next_cfg = sent + 40 + $urandom_range(30);
                send_idle_pct = s_pct;
            end
            if ($urandom_range(19) == 0)
                tick_now = $urandom;
            else
                tick_now = tick_now + $urandom_range(3);
            kind = $urandom_range(99);
            if (kind < 60)
            begin
                send_item(REQ_ARM, $urandom, tick_now);
                send_item(REQ_SCAN, pick_pressure(), tick_now);
                sent += 2;
                repeat ($urandom_range(3))
                begin
                    tick_now = tick_now + $urandom_range(3);
                    send_item(REQ_SCAN, pick_pressure(), tick_now);
                    sent++;
                end
            end
            else if (kind < 70)
            begin
                send_item(REQ_SCAN, pick_pressure(), tick_now);
                sent++;
            end
            else if (kind < 76)
            begin
                send_item(REQ_CLEAR, $urandom, tick_now);
                sent++;
            end
            else if (kind < 81)
                send_item(REQ_UNUSED, $urandom, $urandom);
            else if (kind < 88)
            begin
                send_item(REQ_ARM, $urandom, $urandom);
                sent++;
            end
            else
            begin
                send_item(REQ_SCAN, $urandom, $urandom);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(250, 20, 62);
        run_random_phase(250, 62, 20);
        run_random_phase(250, 0, 0);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_request = 0;
        hold_left = 0;
        tick_now = '0;
        send_idle_pct = 20;
        recv_stall_pct = 62;
        chan_cfg = make_cfg(MODE_SIMPLE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, '0, 1'b1);
        clear_channel();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_defaults();
        test_level_extremes();
        test_modes();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
